/* design/cpualu_pkg.sv */
// ----------------------------------------------------------------------------
// cpualu_pkg: shared types and constants for the eight-bit cpu alu
// operation codes, flag bit positions and field widths
// ----------------------------------------------------------------------------
package cpualu_pkg;

  localparam int KIND_W  = 5;
  localparam int WORD_W  = 16;
  localparam int BYTE_W  = 8;
  localparam int BIDX_W  = 3;
  localparam int FLAGS_W = 4;

  typedef logic [KIND_W-1:0]  kind_t;
  typedef logic [WORD_W-1:0]  word_t;
  typedef logic [BYTE_W-1:0]  byte_t;
  typedef logic [FLAGS_W-1:0] flags_t;

  // flag bit positions
  localparam int FLAG_Z = 3;
  localparam int FLAG_N = 2;
  localparam int FLAG_H = 1;
  localparam int FLAG_C = 0;

  // operation codes
  localparam kind_t KIND_ADD   = 5'd0;
  localparam kind_t KIND_ADC   = 5'd1;
  localparam kind_t KIND_SUB   = 5'd2;
  localparam kind_t KIND_SBC   = 5'd3;
  localparam kind_t KIND_AND   = 5'd4;
  localparam kind_t KIND_XOR   = 5'd5;
  localparam kind_t KIND_OR    = 5'd6;
  localparam kind_t KIND_CP    = 5'd7;
  localparam kind_t KIND_INC   = 5'd8;
  localparam kind_t KIND_DEC   = 5'd9;
  localparam kind_t KIND_RLC   = 5'd10;
  localparam kind_t KIND_RRC   = 5'd11;
  localparam kind_t KIND_RL    = 5'd12;
  localparam kind_t KIND_RR    = 5'd13;
  localparam kind_t KIND_SLA   = 5'd14;
  localparam kind_t KIND_SRA   = 5'd15;
  localparam kind_t KIND_SRL   = 5'd16;
  localparam kind_t KIND_SWAP  = 5'd17;
  localparam kind_t KIND_BIT   = 5'd18;
  localparam kind_t KIND_RES   = 5'd19;
  localparam kind_t KIND_SET   = 5'd20;
  localparam kind_t KIND_DAA   = 5'd21;
  localparam kind_t KIND_CPL   = 5'd22;
  localparam kind_t KIND_SCF   = 5'd23;
  localparam kind_t KIND_CCF   = 5'd24;
  localparam kind_t KIND_RLCA  = 5'd25;
  localparam kind_t KIND_RRCA  = 5'd26;
  localparam kind_t KIND_RLA   = 5'd27;
  localparam kind_t KIND_RRA   = 5'd28;
  localparam kind_t KIND_ADD16 = 5'd29;
  localparam kind_t KIND_ADDSP = 5'd30;

  // decimal adjust constants
  localparam byte_t DAA_LO_ADJ = 8'h06;
  localparam byte_t DAA_HI_ADJ = 8'h60;
  localparam byte_t DAA_HI_MAX = 8'h99;
  localparam logic [3:0] DAA_LO_MAX = 4'h9;

endpackage

/* design/cpu_alu_with_flags.sv */
// ----------------------------------------------------------------------------
// cpu_alu_with_flags: eight-bit cpu alu with z/n/h/c flags
// registered input, one pass of alu logic, registered result
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid / in_stall carry one beat per operation: the
//   operation code, two 16-bit operands, a bit index and the current flags
//   result channel: out_valid / out_stall carry one beat per operation: the
//   16-bit result (upper byte zero for 8-bit operations) and the new flags
//   path: a beat accepted into the input register passes the alu and is
//   captured in the result register, which drives the result ports
//   throughput: one beat per cycle; the alu is a single combinational pass
//   between the input register and the result register, so nothing limits
//   the rate but the receiver
//   stall: when out_stall is held, the result register holds its beat and
//   an empty input register still takes one more beat; in_stall rises only
//   when both registers are full and the receiver stalls
//   reset: rst_n (synchronous, active low) empties both registers; no
//   payload is cleared, no state survives between beats
// ----------------------------------------------------------------------------
module cpu_alu_with_flags (
  input  logic                        clk,
  input  logic                        rst_n,
  // input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  cpualu_pkg::kind_t           in_kind,
  input  cpualu_pkg::word_t           in_operand_a,
  input  cpualu_pkg::word_t           in_operand_b,
  input  logic [cpualu_pkg::BIDX_W-1:0] in_bit_index,
  input  cpualu_pkg::flags_t          in_flags_in,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output cpualu_pkg::word_t           out_result,
  output cpualu_pkg::flags_t          out_flags_out
);

  // input register stage
  logic                          s1_valid_r, s1_valid_nxt;
  cpualu_pkg::kind_t             kind_r;
  cpualu_pkg::word_t             opa_r;
  cpualu_pkg::word_t             opb_r;
  logic [cpualu_pkg::BIDX_W-1:0] bidx_r;
  cpualu_pkg::flags_t            flg_r;

  // result register stage
  logic                          s2_valid_r, s2_valid_nxt;
  cpualu_pkg::word_t             result_r, result_nxt;
  cpualu_pkg::flags_t            flags_r, flags_nxt;

  logic s2_adv;   // result register may load
  logic s1_adv;   // input register may load

  // handshake: result register frees when empty or its beat is taken
  assign s2_adv   = !s2_valid_r || !out_stall;
  assign s1_adv   = !s1_valid_r || s2_adv;
  assign in_stall = !s1_adv;

  assign s1_valid_nxt = s1_adv ? in_valid : s1_valid_r;
  assign s2_valid_nxt = s2_adv ? s1_valid_r : s2_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      kind_r <= in_kind;
      opa_r  <= in_operand_a;
      opb_r  <= in_operand_b;
      bidx_r <= in_bit_index;
      flg_r  <= in_flags_in;
    end
    if (s2_adv) begin
      result_r <= result_nxt;
      flags_r  <= flags_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // alu datapath
  // ---------------------------------------------------------------------------
  cpualu_pkg::byte_t a8, b8;
  logic              cf, cin;
  logic [8:0]        add9, sub9;      // 8-bit sum / difference with carry out
  logic [4:0]        addlo5, sublo5;  // low nibble, for half carry / borrow
  logic [16:0]       add17;           // 16-bit add with carry out
  logic [12:0]       add13;           // bit-11 half carry for add16
  cpualu_pkg::word_t sp_sum;
  cpualu_pkg::byte_t bit_mask;
  cpualu_pkg::byte_t daa_adj;
  logic              daa_c;
  cpualu_pkg::byte_t r8;
  cpualu_pkg::flags_t fl;
  logic              wide;

  assign a8  = opa_r[7:0];
  assign b8  = opb_r[7:0];
  assign cf  = flg_r[cpualu_pkg::FLAG_C];
  assign cin = ((kind_r == cpualu_pkg::KIND_ADC) || (kind_r == cpualu_pkg::KIND_SBC)) ? cf : 1'b0;

  assign add9   = {1'b0, a8} + {1'b0, b8} + {8'h00, cin};
  assign addlo5 = {1'b0, a8[3:0]} + {1'b0, b8[3:0]} + {4'h0, cin};
  assign sub9   = {1'b0, a8} - {1'b0, b8} - {8'h00, cin};
  assign sublo5 = {1'b0, a8[3:0]} - {1'b0, b8[3:0]} - {4'h0, cin};
  assign add17  = {1'b0, opa_r} + {1'b0, opb_r};
  assign add13  = {1'b0, opa_r[11:0]} + {1'b0, opb_r[11:0]};
  // sp plus sign-extended offset byte
  assign sp_sum   = opa_r + {{8{b8[7]}}, b8};
  assign bit_mask = 8'h01 << bidx_r;

  // decimal adjust correction
  always_comb begin
    daa_adj = 8'h00;
    daa_c   = cf;
    if (!flg_r[cpualu_pkg::FLAG_N]) begin
      if (cf || (a8 > cpualu_pkg::DAA_HI_MAX)) begin
        daa_adj = daa_adj | cpualu_pkg::DAA_HI_ADJ;
        daa_c   = 1'b1;
      end
      if (flg_r[cpualu_pkg::FLAG_H] || (a8[3:0] > cpualu_pkg::DAA_LO_MAX)) begin
        daa_adj = daa_adj | cpualu_pkg::DAA_LO_ADJ;
      end
    end else begin
      if (flg_r[cpualu_pkg::FLAG_H]) begin
        daa_adj = daa_adj | cpualu_pkg::DAA_LO_ADJ;
      end
      if (cf) begin
        daa_adj = daa_adj | cpualu_pkg::DAA_HI_ADJ;
      end
    end
  end

  // flags are packed {z, n, h, c}
  always_comb begin
    r8         = 8'h00;
    fl         = flg_r;
    wide       = 1'b0;
    result_nxt = 16'h0000;
    unique case (kind_r)
      cpualu_pkg::KIND_ADD, cpualu_pkg::KIND_ADC: begin
        r8 = add9[7:0];
        fl = {r8 == 8'h00, 1'b0, addlo5[4], add9[8]};
      end
      cpualu_pkg::KIND_SUB, cpualu_pkg::KIND_SBC: begin
        r8 = sub9[7:0];
        fl = {r8 == 8'h00, 1'b1, sublo5[4], sub9[8]};
      end
      cpualu_pkg::KIND_CP: begin
        // flags of the subtract, accumulator unchanged
        r8 = a8;
        fl = {sub9[7:0] == 8'h00, 1'b1, sublo5[4], sub9[8]};
      end
      cpualu_pkg::KIND_AND: begin
        r8 = a8 & b8;
        fl = {r8 == 8'h00, 1'b0, 1'b1, 1'b0};
      end
      cpualu_pkg::KIND_XOR: begin
        r8 = a8 ^ b8;
        fl = {r8 == 8'h00, 3'b000};
      end
      cpualu_pkg::KIND_OR: begin
        r8 = a8 | b8;
        fl = {r8 == 8'h00, 3'b000};
      end
      cpualu_pkg::KIND_INC: begin
        r8 = a8 + 8'h01;
        fl = {r8 == 8'h00, 1'b0, a8[3:0] == 4'hf, cf};
      end
      cpualu_pkg::KIND_DEC: begin
        r8 = a8 - 8'h01;
        fl = {r8 == 8'h00, 1'b1, r8[3:0] == 4'hf, cf};
      end
      cpualu_pkg::KIND_RLC, cpualu_pkg::KIND_RLCA: begin
        r8 = {a8[6:0], a8[7]};
        fl = {r8 == 8'h00, 2'b00, a8[7]};
      end
      cpualu_pkg::KIND_RRC, cpualu_pkg::KIND_RRCA: begin
        r8 = {a8[0], a8[7:1]};
        fl = {r8 == 8'h00, 2'b00, a8[0]};
      end
      cpualu_pkg::KIND_RL, cpualu_pkg::KIND_RLA: begin
        r8 = {a8[6:0], cf};
        fl = {r8 == 8'h00, 2'b00, a8[7]};
      end
      cpualu_pkg::KIND_RR, cpualu_pkg::KIND_RRA: begin
        r8 = {cf, a8[7:1]};
        fl = {r8 == 8'h00, 2'b00, a8[0]};
      end
      cpualu_pkg::KIND_SLA: begin
        r8 = {a8[6:0], 1'b0};
        fl = {r8 == 8'h00, 2'b00, a8[7]};
      end
      cpualu_pkg::KIND_SRA: begin
        r8 = {a8[7], a8[7:1]};
        fl = {r8 == 8'h00, 2'b00, a8[0]};
      end
      cpualu_pkg::KIND_SRL: begin
        r8 = {1'b0, a8[7:1]};
        fl = {r8 == 8'h00, 2'b00, a8[0]};
      end
      cpualu_pkg::KIND_SWAP: begin
        r8 = {a8[3:0], a8[7:4]};
        fl = {r8 == 8'h00, 3'b000};
      end
      cpualu_pkg::KIND_BIT: begin
        r8 = a8;
        fl = {(a8 & bit_mask) == 8'h00, 1'b0, 1'b1, cf};
      end
      cpualu_pkg::KIND_RES: begin
        r8 = a8 & ~bit_mask;
      end
      cpualu_pkg::KIND_SET: begin
        r8 = a8 | bit_mask;
      end
      cpualu_pkg::KIND_DAA: begin
        r8 = flg_r[cpualu_pkg::FLAG_N] ? (a8 - daa_adj) : (a8 + daa_adj);
        fl = {r8 == 8'h00, flg_r[cpualu_pkg::FLAG_N], 1'b0, daa_c};
      end
      cpualu_pkg::KIND_CPL: begin
        r8 = ~a8;
        fl = {flg_r[cpualu_pkg::FLAG_Z], 1'b1, 1'b1, cf};
      end
      cpualu_pkg::KIND_SCF: begin
        r8 = a8;
        fl = {flg_r[cpualu_pkg::FLAG_Z], 3'b001};
      end
      cpualu_pkg::KIND_CCF: begin
        r8 = a8;
        fl = {flg_r[cpualu_pkg::FLAG_Z], 2'b00, ~cf};
      end
      cpualu_pkg::KIND_ADD16: begin
        wide       = 1'b1;
        result_nxt = add17[15:0];
        fl         = {flg_r[cpualu_pkg::FLAG_Z], 1'b0, add13[12], add17[16]};
      end
      cpualu_pkg::KIND_ADDSP: begin
        // h and c from the unsigned low nibble / low byte adds
        wide       = 1'b1;
        result_nxt = sp_sum;
        fl         = {2'b00, addlo5[4], add9[8]};
      end
      default: begin
        // unused code: zero result, flags pass through
        wide       = 1'b1;
        result_nxt = 16'h0000;
        fl         = flg_r;
      end
    endcase
    if (!wide) begin
      result_nxt = {8'h00, r8};
    end
    // accumulator rotates always clear z
    if ((kind_r >= cpualu_pkg::KIND_RLCA) && (kind_r <= cpualu_pkg::KIND_RRA)) begin
      fl[cpualu_pkg::FLAG_Z] = 1'b0;
    end
    flags_nxt = fl;
  end

  assign out_valid     = s2_valid_r;
  assign out_result    = result_r;
  assign out_flags_out = flags_r;

endmodule

/* design/cpualu_checker.sv */
// ----------------------------------------------------------------------------
// cpualu_checker: port-level assertions for the cpu alu
// handshake holds, latency and back pressure as seen on the ports
// ----------------------------------------------------------------------------
module cpualu_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input cpualu_pkg::word_t    out_result,
  input cpualu_pkg::flags_t   out_flags_out
);

  // a stalled result beat stays valid
  a_out_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  // a stalled result beat keeps its payload
  a_out_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_result) && $stable(out_flags_out))
    else $error("result payload changed while stalled");

  // an accepted beat reaches the result port unless the receiver stalls
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) ##1 !out_stall |=> out_valid)
    else $error("accepted beat did not reach the result port");

  // back pressure only when a result beat is waiting
  a_stall_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with no waiting result beat");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind cpu_alu_with_flags cpualu_checker u_cpualu_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_result    (out_result),
  .out_flags_out (out_flags_out)
);

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb: self-checking bench for the eight-bit cpu alu with flags
// drives operation beats through the valid/stall input channel, predicts
// result and flags for every accepted beat, checks each result beat in order
// ----------------------------------------------------------------------------
class alu_scoreboard;

  typedef struct {
    cpualu_pkg::word_t  result;
    cpualu_pkg::flags_t flags;
  } alu_result_t;

  alu_result_t result_q[$];
  int          errors = 0;

  task report(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  function int pending();
    return result_q.size();
  endfunction

  // flags are packed {z, n, h, c}, matching FLAG_Z..FLAG_C
  function alu_result_t alu_compute(input cpualu_pkg::kind_t k,
                                    input cpualu_pkg::word_t a16,
                                    input cpualu_pkg::word_t b16,
                                    input logic [cpualu_pkg::BIDX_W-1:0] bi,
                                    input cpualu_pkg::flags_t f);
    alu_result_t       res;
    cpualu_pkg::byte_t a;
    cpualu_pkg::byte_t b;
    cpualu_pkg::byte_t r8;
    logic              c;
    logic              cin;
    logic              cy;
    logic [8:0]        t9;
    logic [4:0]        lo5;
    logic [16:0]       t17;
    logic [12:0]       h13;
    a   = a16[7:0];
    b   = b16[7:0];
    c   = f[cpualu_pkg::FLAG_C];
    cin = 1'b0;
    r8  = '0;
    res.result = '0;
    res.flags  = f;
    case (k)
      cpualu_pkg::KIND_ADD, cpualu_pkg::KIND_ADC: begin
        cin = (k == cpualu_pkg::KIND_ADC) ? c : 1'b0;
        t9  = {1'b0, a} + {1'b0, b} + {8'h00, cin};
        lo5 = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'h0, cin};
        res.result = {8'h00, t9[7:0]};
        res.flags  = {t9[7:0] == 8'h00, 1'b0, lo5[4], t9[8]};
      end
      cpualu_pkg::KIND_SUB, cpualu_pkg::KIND_SBC, cpualu_pkg::KIND_CP: begin
        cin = (k == cpualu_pkg::KIND_SBC) ? c : 1'b0;
        t9  = {1'b0, a} - {1'b0, b} - {8'h00, cin};
        lo5 = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'h0, cin};
        // compare keeps the accumulator but flags come from the difference
        res.result = {8'h00, (k == cpualu_pkg::KIND_CP) ? a : t9[7:0]};
        res.flags  = {t9[7:0] == 8'h00, 1'b1, lo5[4], t9[8]};
      end
      cpualu_pkg::KIND_AND: begin
        r8 = a & b;
        res.result = {8'h00, r8};
        res.flags  = {r8 == 8'h00, 1'b0, 1'b1, 1'b0};
      end
      cpualu_pkg::KIND_XOR, cpualu_pkg::KIND_OR: begin
        r8 = (k == cpualu_pkg::KIND_XOR) ? (a ^ b) : (a | b);
        res.result = {8'h00, r8};
        res.flags  = {r8 == 8'h00, 3'b000};
      end
      cpualu_pkg::KIND_INC: begin
        r8 = a + 8'd1;
        res.result = {8'h00, r8};
        res.flags  = {r8 == 8'h00, 1'b0, a[3:0] == 4'hf, c};
      end
      cpualu_pkg::KIND_DEC: begin
        r8 = a - 8'd1;
        res.result = {8'h00, r8};
        res.flags  = {r8 == 8'h00, 1'b1, r8[3:0] == 4'hf, c};
      end
      cpualu_pkg::KIND_RLC, cpualu_pkg::KIND_RLCA, cpualu_pkg::KIND_RL,
      cpualu_pkg::KIND_RLA, cpualu_pkg::KIND_SLA: begin
        if (k == cpualu_pkg::KIND_RLC || k == cpualu_pkg::KIND_RLCA) begin
          r8 = {a[6:0], a[7]};
        end else if (k == cpualu_pkg::KIND_SLA) begin
          r8 = {a[6:0], 1'b0};
        end else begin
          r8 = {a[6:0], c};
        end
        res.result = {8'h00, r8};
        res.flags  = {r8 == 8'h00, 2'b00, a[7]};
      end
      cpualu_pkg::KIND_RRC, cpualu_pkg::KIND_RRCA, cpualu_pkg::KIND_RR,
      cpualu_pkg::KIND_RRA, cpualu_pkg::KIND_SRA, cpualu_pkg::KIND_SRL: begin
        case (k)
          cpualu_pkg::KIND_RRC, cpualu_pkg::KIND_RRCA: r8 = {a[0], a[7:1]};
          cpualu_pkg::KIND_RR, cpualu_pkg::KIND_RRA:   r8 = {c, a[7:1]};
          cpualu_pkg::KIND_SRA:                        r8 = {a[7], a[7:1]};
          default:                                     r8 = {1'b0, a[7:1]};
        endcase
        res.result = {8'h00, r8};
        res.flags  = {r8 == 8'h00, 2'b00, a[0]};
      end
      cpualu_pkg::KIND_SWAP: begin
        r8 = {a[3:0], a[7:4]};
        res.result = {8'h00, r8};
        res.flags  = {r8 == 8'h00, 3'b000};
      end
      cpualu_pkg::KIND_BIT: begin
        res.result = {8'h00, a};
        res.flags  = {~a[bi], 1'b0, 1'b1, c};
      end
      cpualu_pkg::KIND_RES: begin
        r8 = a & ~(8'h01 << bi);
        res.result = {8'h00, r8};
      end
      cpualu_pkg::KIND_SET: begin
        r8 = a | (8'h01 << bi);
        res.result = {8'h00, r8};
      end
      cpualu_pkg::KIND_DAA: begin
        r8 = a;
        cy = c;
        if (!f[cpualu_pkg::FLAG_N]) begin
          if (c || a > cpualu_pkg::DAA_HI_MAX) begin
            r8 = r8 + cpualu_pkg::DAA_HI_ADJ;
            cy = 1'b1;
          end
          if (f[cpualu_pkg::FLAG_H] || a[3:0] > cpualu_pkg::DAA_LO_MAX)
            r8 = r8 + cpualu_pkg::DAA_LO_ADJ;
        end else begin
          if (f[cpualu_pkg::FLAG_H]) r8 = r8 - cpualu_pkg::DAA_LO_ADJ;
          if (c) r8 = r8 - cpualu_pkg::DAA_HI_ADJ;
        end
        res.result = {8'h00, r8};
        res.flags  = {r8 == 8'h00, f[cpualu_pkg::FLAG_N], 1'b0, cy};
      end
      cpualu_pkg::KIND_CPL: begin
        res.result = {8'h00, ~a};
        res.flags  = {f[cpualu_pkg::FLAG_Z], 1'b1, 1'b1, c};
      end
      cpualu_pkg::KIND_SCF: begin
        res.result = {8'h00, a};
        res.flags  = {f[cpualu_pkg::FLAG_Z], 3'b001};
      end
      cpualu_pkg::KIND_CCF: begin
        res.result = {8'h00, a};
        res.flags  = {f[cpualu_pkg::FLAG_Z], 2'b00, ~c};
      end
      cpualu_pkg::KIND_ADD16: begin
        t17 = {1'b0, a16} + {1'b0, b16};
        h13 = {1'b0, a16[11:0]} + {1'b0, b16[11:0]};
        res.result = t17[15:0];
        res.flags  = {f[cpualu_pkg::FLAG_Z], 1'b0, h13[12], t17[16]};
      end
      cpualu_pkg::KIND_ADDSP: begin
        lo5 = {1'b0, a16[3:0]} + {1'b0, b[3:0]};
        t9  = {1'b0, a16[7:0]} + {1'b0, b};
        res.result = a16 + {{8{b[7]}}, b};
        res.flags  = {2'b00, lo5[4], t9[8]};
      end
      default: begin
        res.result = '0;
        res.flags  = f;
      end
    endcase
    // accumulator rotates always clear z
    if (k == cpualu_pkg::KIND_RLCA || k == cpualu_pkg::KIND_RRCA ||
        k == cpualu_pkg::KIND_RLA || k == cpualu_pkg::KIND_RRA) begin
      res.flags[cpualu_pkg::FLAG_Z] = 1'b0;
    end
    return res;
  endfunction

  function void note_input(input cpualu_pkg::kind_t k, input cpualu_pkg::word_t a16,
                           input cpualu_pkg::word_t b16,
                           input logic [cpualu_pkg::BIDX_W-1:0] bi,
                           input cpualu_pkg::flags_t f);
    result_q.push_back(alu_compute(k, a16, b16, bi, f));
  endfunction

  task check_result(input cpualu_pkg::word_t r, input cpualu_pkg::flags_t f);
    alu_result_t exp_res;
    if (result_q.size() == 0) begin
      report($sformatf("result beat %h/%h with nothing pending", r, f));
    end else begin
      exp_res = result_q.pop_front();
      if (r !== exp_res.result)
        report($sformatf("result %h, predicted %h", r, exp_res.result));
      if (f !== exp_res.flags)
        report($sformatf("flags %b, predicted %b", f, exp_res.flags));
    end
  endtask

endclass

module tb;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 80;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_ITEMS = 490;

  typedef logic [cpualu_pkg::BIDX_W-1:0] bidx_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  cpualu_pkg::kind_t     in_kind;
  cpualu_pkg::word_t     in_operand_a;
  cpualu_pkg::word_t     in_operand_b;
  bidx_t                 in_bit_index;
  cpualu_pkg::flags_t    in_flags_in;
  logic                  out_valid;
  logic                  out_stall;
  cpualu_pkg::word_t     out_result;
  cpualu_pkg::flags_t    out_flags_out;

  alu_scoreboard sb = new();

  // idle odds in percent, set per phase by the main sequence
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  // request for one long receiver hold-off
  bit hold_req = 1'b0;
  int hold_left = 0;
  int cycle_count = 0;

  cpu_alu_with_flags uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_kind       (in_kind),
    .in_operand_a  (in_operand_a),
    .in_operand_b  (in_operand_b),
    .in_bit_index  (in_bit_index),
    .in_flags_in   (in_flags_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_result    (out_result),
    .out_flags_out (out_flags_out)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // both channels sampled at the edge, pre-edge values only
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall)
        sb.note_input(in_kind, in_operand_a, in_operand_b, in_bit_index, in_flags_in);
      if (out_valid && !out_stall)
        sb.check_result(out_result, out_flags_out);
    end
  end

  // receiver: random stall per cycle, or a long hold-off when asked so that
  // both internal registers fill and the block stalls its input
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // one input beat: present, wait for acceptance, then maybe idle a while;
  // valid only drops inside the idle branch so back-to-back beats keep it high
  task drive_op(input cpualu_pkg::kind_t k, input cpualu_pkg::word_t a,
                input cpualu_pkg::word_t b, input bidx_t bi,
                input cpualu_pkg::flags_t f);
    in_valid     <= 1'b1;
    in_kind      <= k;
    in_operand_a <= a;
    in_operand_b <= b;
    in_bit_index <= bi;
    in_flags_in  <= f;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  // operand mix: plain random words plus the usual corner values
  function cpualu_pkg::word_t pick_operand();
    cpualu_pkg::byte_t corner;
    case ($urandom_range(3))
      0: corner = 8'h00;
      1: corner = 8'hff;
      2: corner = 8'h80;
      default: corner = 8'h7f;
    endcase
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'hffff;
      2: return {8'($urandom_range(255)), corner};
      3: return {8'h00, 8'($urandom_range(255))};
      default: return cpualu_pkg::word_t'($urandom);
    endcase
  endfunction

  // every code, including the unused one, gets equal odds
  task random_ops(input int count);
    for (int i = 0; i < count; i++) begin
      drive_op(cpualu_pkg::kind_t'($urandom_range(31)), pick_operand(), pick_operand(),
               bidx_t'($urandom_range(7)), cpualu_pkg::flags_t'($urandom_range(15)));
    end
  endtask

  initial begin
    // known values on every input from time zero
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_kind      = cpualu_pkg::KIND_ADD;
    in_operand_a = '0;
    in_operand_b = '0;
    in_bit_index = '0;
    in_flags_in  = '0;
    out_stall    = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // sender idles less than the receiver in the first phase
    send_idle_pct = 37;
    recv_idle_pct = 48;

    // directed: every code once with operand extremes spread across it
    for (int k = 0; k < 32; k++) begin
      drive_op(cpualu_pkg::kind_t'(k), k[0] ? 16'hffff : 16'h0f80,
               k[1] ? 16'h0001 : 16'hff80, bidx_t'(k), cpualu_pkg::flags_t'(k));
    end
    // decimal adjust after addition: high and low correction, carry set
    drive_op(cpualu_pkg::KIND_DAA, 16'h009a, 16'h0000, '0, 4'b0000);
    // decimal adjust after addition driven by incoming h and c
    drive_op(cpualu_pkg::KIND_DAA, 16'h0045, 16'h0000, '0, 4'b0011);
    // decimal adjust after subtraction with h and c, carry kept
    drive_op(cpualu_pkg::KIND_DAA, 16'h0000, 16'h0000, '0, 4'b0111);
    // stack pointer plus negative offset
    drive_op(cpualu_pkg::KIND_ADDSP, 16'h0001, 16'h00ff, '0, 4'b1111);
    // 16-bit add carrying out of bit 11 only
    drive_op(cpualu_pkg::KIND_ADD16, 16'h0fff, 16'h0001, '0, 4'b1000);

    random_ops(PHASE_ITEMS);

    // roles swapped
    send_idle_pct = 48;
    recv_idle_pct = 37;
    random_ops(PHASE_ITEMS);

    // full rate, with one long receiver hold-off while beats keep coming
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = 1'b1;
    random_ops(PHASE_ITEMS);
    in_valid <= 1'b0;

    // drain, then keep watching the result port to catch stray result beats
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
